// ----- rtl/dbd_pkg.sv -----
// dbd_pkg: shared types and constants of the detector box decoder.
// Used by every module of the block but dbd_fifo; depends on nothing.
package dbd_pkg;

    localparam int MAX_CLASSES_DEF = 128;
    localparam int MAX_IMAGE_DEF   = 4096;
    localparam int FRAC_BITS_DEF   = 14;
    localparam int QUEUE_DEPTH     = 2;

    localparam int VALUE_W = 24;
    localparam int INV_W   = 22;
    localparam int INV_FRAC = 16;
    localparam int PAD_W   = 10;
    localparam int IMG_W   = 13;
    localparam int THR_W   = 15;
    localparam int NCLS_W  = 8;
    localparam int CLASS_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_INV_RATIO_X     = 3'd1,
        REG_INV_RATIO_Y     = 3'd2,
        REG_PAD_LEFT        = 3'd3,
        REG_PAD_TOP         = 3'd4,
        REG_IMAGE_WIDTH     = 3'd5,
        REG_IMAGE_HEIGHT    = 3'd6,
        REG_CLASS_CNT       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  score_threshold;
        logic [INV_W-1:0]  inv_ratio_x;
        logic [INV_W-1:0]  inv_ratio_y;
        logic [PAD_W-1:0]  pad_left;
        logic [PAD_W-1:0]  pad_top;
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
        logic [NCLS_W-1:0] class_cnt;
    } t_cfg;

    // Row that passed the threshold, handed from front to back.
    typedef struct packed {
        logic [VALUE_W-1:0] cx;
        logic [VALUE_W-1:0] cy;
        logic [VALUE_W-1:0] w;
        logic [VALUE_W-1:0] h;
        logic [VALUE_W-1:0] score;
        logic [CLASS_W-1:0] cls;
    } t_cand;

    typedef struct packed {
        logic [CLASS_W-1:0] class_id;
        logic [VALUE_W-1:0] confidence;
        logic [11:0]        box_left;
        logic [11:0]        box_top;
        logic [12:0]        box_width;
        logic [12:0]        box_height;
    } t_result;

endpackage

// ----- rtl/dbd_fifo.sv -----
// dbd_fifo: small register queue with push/full and pop/empty sides.
// Depends on nothing; payload is a plain vector.
module dbd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ----- rtl/dbd_front.sv -----
// dbd_front: row sequencer; stores coordinates, tracks the best class and
// issues a candidate when a row ends at or above threshold. Uses dbd_pkg.
module dbd_front #(
    parameter int MAX_CLASSES = dbd_pkg::MAX_CLASSES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dbd_pkg::t_cfg               i_cfg,
    input  logic                        i_accept,
    input  logic [dbd_pkg::VALUE_W-1:0] i_value,
    output logic                        o_cand_valid,
    output dbd_pkg::t_cand              o_cand
);
    localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

    logic [dbd_pkg::VALUE_W-1:0] r_coord [4];
    logic [1:0]                  r_phase;
    logic                        r_in_scores;
    logic [CLS_W-1:0]            r_idx;
    logic [dbd_pkg::VALUE_W-1:0] r_best;
    logic [CLS_W-1:0]            r_best_cls;

    logic [dbd_pkg::VALUE_W-1:0] n_best;
    logic [CLS_W-1:0]            n_best_cls;
    logic [31:0]                 nc;
    logic [CLS_W-1:0]            last_idx;
    logic                        take, row_end, pass;

    // effective class count: zero means one, capped at MAX_CLASSES
    always_comb begin
        nc = 32'(i_cfg.class_cnt);
        if (nc == 32'd0) begin
            nc = 32'd1;
        end
        if (nc > 32'(MAX_CLASSES)) begin
            nc = 32'(MAX_CLASSES);
        end
        last_idx = CLS_W'(nc - 32'd1);
    end

    // first score always loads; later ones only when strictly greater
    assign take       = (r_idx == '0) || (i_value > r_best);
    assign n_best     = take ? i_value : r_best;
    assign n_best_cls = take ? r_idx : r_best_cls;
    assign row_end    = (r_idx >= last_idx);
    assign pass       = (n_best >= dbd_pkg::VALUE_W'(i_cfg.score_threshold));

    assign o_cand_valid = i_accept && r_in_scores && row_end && pass;
    always_comb begin
        o_cand.cx    = r_coord[0];
        o_cand.cy    = r_coord[1];
        o_cand.w     = r_coord[2];
        o_cand.h     = r_coord[3];
        o_cand.score = n_best;
        o_cand.cls   = dbd_pkg::CLASS_W'(n_best_cls);
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_in_scores) begin
            r_coord[r_phase] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_in_scores <= 1'b0;
            r_idx       <= '0;
            r_best      <= '0;
            r_best_cls  <= '0;
        end else if (i_accept) begin
            if (!r_in_scores) begin
                r_phase <= r_phase + 1'b1;
                if (r_phase == 2'd3) begin
                    r_in_scores <= 1'b1;
                    r_idx       <= '0;
                end
            end else begin
                r_best     <= n_best;
                r_best_cls <= n_best_cls;
                if (row_end) begin
                    r_in_scores <= 1'b0;
                    r_phase     <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end
endmodule

// ----- rtl/dbd_back.sv -----
// dbd_back: three-stage box arithmetic (pad removal, scaling, rounding)
// followed by clipping into the result queue. Uses dbd_pkg.
module dbd_back #(
    parameter int MAX_IMAGE = dbd_pkg::MAX_IMAGE_DEF,
    parameter int FRAC_BITS = dbd_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dbd_pkg::t_cfg   i_cfg,
    input  logic            i_cand_empty,
    input  dbd_pkg::t_cand  i_cand,
    output logic            o_cand_pop,
    input  logic            i_res_full,
    output logic            o_res_valid,
    output dbd_pkg::t_result o_res
);
    localparam int VW    = dbd_pkg::VALUE_W;
    localparam int PADSW = dbd_pkg::PAD_W + FRAC_BITS;
    localparam int CW    = ((PADSW > VW) ? PADSW : VW) + 1;
    localparam int PW    = CW + dbd_pkg::INV_W + 1;
    localparam int EW    = VW + dbd_pkg::INV_W;
    localparam int EXW   = EW + 1;
    localparam int S     = FRAC_BITS + dbd_pkg::INV_FRAC;
    localparam int NUM_W = PW + 2;
    localparam int SW    = NUM_W - S - 2;
    localparam int ZW    = EXW - S;
    localparam int IMW0  = $clog2(MAX_IMAGE + 1);
    localparam int IMW   = (IMW0 > dbd_pkg::IMG_W) ? IMW0 : dbd_pkg::IMG_W;
    localparam int RW0   = (SW > ZW) ? SW : ZW;
    localparam int RW    = ((RW0 > IMW) ? RW0 : IMW) + 1;
    localparam logic [NUM_W-1:0] RND_START = {{(NUM_W-1){1'b0}}, 1'b1} << S;
    localparam logic [EXW-1:0]   RND_SIZE  = {{(EXW-1){1'b0}}, 1'b1} << (S - 1);

    logic advance;

    // stage 1: padding removed
    logic                            r_s1_valid;
    logic signed [CW-1:0]            r_s1_cx, r_s1_cy;
    logic [VW-1:0]                   r_s1_w, r_s1_h, r_s1_conf;
    logic [dbd_pkg::CLASS_W-1:0]     r_s1_cls;
    // stage 2: scaled products
    logic                            r_s2_valid;
    logic signed [PW-1:0]            r_s2_pos_x, r_s2_pos_y;
    logic [EW-1:0]                   r_s2_ext_x, r_s2_ext_y;
    logic [VW-1:0]                   r_s2_conf;
    logic [dbd_pkg::CLASS_W-1:0]     r_s2_cls;
    // stage 3: rounded start and size
    logic                            r_s3_valid;
    logic [SW-1:0]                   r_s3_st_x, r_s3_st_y;
    logic [ZW-1:0]                   r_s3_sz_x, r_s3_sz_y;
    logic [VW-1:0]                   r_s3_conf;
    logic [dbd_pkg::CLASS_W-1:0]     r_s3_cls;

    logic signed [NUM_W-1:0] num_x, num_y;
    logic [EXW-1:0]          szr_x, szr_y;
    logic [SW-1:0]           st_x, st_y;
    logic [25:0]             clip_x, clip_y;

    // {empty, start, length} of one axis after intersecting with [0, lim)
    function automatic logic [25:0] clip_axis(input logic [SW-1:0] st,
                                              input logic [ZW-1:0] sz,
                                              input logic [dbd_pkg::IMG_W-1:0] lim);
        logic [RW-1:0] lim_r, right;
        logic          emp;
        lim_r = (RW'(lim) > RW'(MAX_IMAGE)) ? RW'(MAX_IMAGE) : RW'(lim);
        right = RW'(st) + RW'(sz);
        if (right > lim_r) begin
            right = lim_r;
        end
        emp = (right <= RW'(st));
        return {emp, 12'(st), 13'(right - RW'(st))};
    endfunction

    assign advance    = !(r_s3_valid && i_res_full);
    assign o_cand_pop = advance && !i_cand_empty;

    always_comb begin
        num_x = (NUM_W'(r_s2_pos_x) <<< 1) - $signed(NUM_W'(r_s2_ext_x))
                + $signed(RND_START);
        num_y = (NUM_W'(r_s2_pos_y) <<< 1) - $signed(NUM_W'(r_s2_ext_y))
                + $signed(RND_START);
        st_x  = num_x[NUM_W-1] ? '0 : num_x[NUM_W-2:S+1];
        st_y  = num_y[NUM_W-1] ? '0 : num_y[NUM_W-2:S+1];
        szr_x = EXW'(r_s2_ext_x) + RND_SIZE;
        szr_y = EXW'(r_s2_ext_y) + RND_SIZE;
    end

    assign clip_x = clip_axis(r_s3_st_x, r_s3_sz_x, i_cfg.image_width);
    assign clip_y = clip_axis(r_s3_st_y, r_s3_sz_y, i_cfg.image_height);

    assign o_res_valid = advance && r_s3_valid;
    always_comb begin
        o_res.class_id   = r_s3_cls;
        o_res.confidence = r_s3_conf;
        if (clip_x[25] || clip_y[25]) begin
            o_res.box_left   = '0;
            o_res.box_top    = '0;
            o_res.box_width  = '0;
            o_res.box_height = '0;
        end else begin
            o_res.box_left   = clip_x[24:13];
            o_res.box_top    = clip_y[24:13];
            o_res.box_width  = clip_x[12:0];
            o_res.box_height = clip_y[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cx   <= CW'(i_cand.cx) - (CW'(i_cfg.pad_left) << FRAC_BITS);
            r_s1_cy   <= CW'(i_cand.cy) - (CW'(i_cfg.pad_top) << FRAC_BITS);
            r_s1_w    <= i_cand.w;
            r_s1_h    <= i_cand.h;
            r_s1_conf <= i_cand.score;
            r_s1_cls  <= i_cand.cls;

            r_s2_pos_x <= PW'(r_s1_cx) * PW'($signed({1'b0, i_cfg.inv_ratio_x}));
            r_s2_pos_y <= PW'(r_s1_cy) * PW'($signed({1'b0, i_cfg.inv_ratio_y}));
            r_s2_ext_x <= EW'(r_s1_w) * EW'(i_cfg.inv_ratio_x);
            r_s2_ext_y <= EW'(r_s1_h) * EW'(i_cfg.inv_ratio_y);
            r_s2_conf  <= r_s1_conf;
            r_s2_cls   <= r_s1_cls;

            r_s3_st_x <= st_x;
            r_s3_st_y <= st_y;
            r_s3_sz_x <= szr_x[EXW-1:S];
            r_s3_sz_y <= szr_y[EXW-1:S];
            r_s3_conf <= r_s2_conf;
            r_s3_cls  <= r_s2_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= !i_cand_empty;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end
endmodule

// ----- rtl/detector_box_decode.sv -----
// Detector box decoder: one row value per cycle in while full is low (the
// rate is set by the single compare of the running maximum), one box
// candidate out for each row whose best class score reaches the threshold.
// A row's last score passes the candidate queue, the three back stages and
// the result queue before its box shows at the result side (empty low).
// Reset (i_rst_n low, synchronous) empties both queues, restarts the row.
module detector_box_decode #(
    parameter int MAX_CLASSES = dbd_pkg::MAX_CLASSES_DEF,
    parameter int MAX_IMAGE   = dbd_pkg::MAX_IMAGE_DEF,
    parameter int FRAC_BITS   = dbd_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input request side
    input  logic                           push,
    output logic                           full,
    input  logic [dbd_pkg::VALUE_W-1:0]    i_value,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic [dbd_pkg::CLASS_W-1:0]    o_class_id,
    output logic [dbd_pkg::VALUE_W-1:0]    o_confidence,
    output logic [11:0]                    o_box_left,
    output logic [11:0]                    o_box_top,
    output logic [12:0]                    o_box_width,
    output logic [12:0]                    o_box_height,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [dbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CAND_W = $bits(dbd_pkg::t_cand);
    localparam int RES_W  = $bits(dbd_pkg::t_result);

    dbd_pkg::t_cfg    r_cfg;
    dbd_pkg::t_cand   front_cand, back_cand;
    dbd_pkg::t_result back_res, out_res;
    logic             accept, cand_push, cand_full, cand_empty, cand_pop;
    logic             res_push, res_full;

    // ---------------------------------------------------------------
    // Configuration registers; written only while the block is idle (a rule
    // for the user, not enforced here), so the front and back read them live.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold <= 15'd4096;
            r_cfg.inv_ratio_x     <= 22'd65536;
            r_cfg.inv_ratio_y     <= 22'd65536;
            r_cfg.pad_left        <= '0;
            r_cfg.pad_top         <= '0;
            r_cfg.image_width     <= 13'd640;
            r_cfg.image_height    <= 13'd640;
            r_cfg.class_cnt       <= 8'd80;
        end else if (i_cfg_we) begin
            case (dbd_pkg::t_reg_idx'(i_cfg_index))
                dbd_pkg::REG_SCORE_THRESHOLD: r_cfg.score_threshold <= 15'(i_cfg_data);
                dbd_pkg::REG_INV_RATIO_X:     r_cfg.inv_ratio_x     <= i_cfg_data;
                dbd_pkg::REG_INV_RATIO_Y:     r_cfg.inv_ratio_y     <= i_cfg_data;
                dbd_pkg::REG_PAD_LEFT:        r_cfg.pad_left        <= 10'(i_cfg_data);
                dbd_pkg::REG_PAD_TOP:         r_cfg.pad_top         <= 10'(i_cfg_data);
                dbd_pkg::REG_IMAGE_WIDTH:     r_cfg.image_width     <= 13'(i_cfg_data);
                dbd_pkg::REG_IMAGE_HEIGHT:    r_cfg.image_height    <= 13'(i_cfg_data);
                dbd_pkg::REG_CLASS_CNT:       r_cfg.class_cnt       <= 8'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Front takes a request whenever the candidate queue has room; a row
    // is at least five requests long, so one free slot is plenty.
    assign full   = cand_full;
    assign accept = push && !full;

    dbd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_value     (i_value),
        .o_cand_valid(cand_push),
        .o_cand      (front_cand)
    );

    // Candidate queue decouples the row sequencer from the box math.
    dbd_fifo #(
        .W    (CAND_W),
        .DEPTH(dbd_pkg::QUEUE_DEPTH)
    ) u_cand_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cand_push),
        .i_data (front_cand),
        .o_full (cand_full),
        .i_pop  (cand_pop),
        .o_empty(cand_empty),
        .o_data (back_cand)
    );

    dbd_back #(
        .MAX_IMAGE(MAX_IMAGE),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cand_empty(cand_empty),
        .i_cand      (back_cand),
        .o_cand_pop  (cand_pop),
        .i_res_full  (res_full),
        .o_res_valid (res_push),
        .o_res       (back_res)
    );

    // Result queue holds finished boxes while the consumer stalls; the
    // back pipeline freezes only when its last stage finds it full.
    dbd_fifo #(
        .W    (RES_W),
        .DEPTH(dbd_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (back_res),
        .o_full (res_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (out_res)
    );

    assign o_class_id   = out_res.class_id;
    assign o_confidence = out_res.confidence;
    assign o_box_left   = out_res.box_left;
    assign o_box_top    = out_res.box_top;
    assign o_box_width  = out_res.box_width;
    assign o_box_height = out_res.box_height;
endmodule

// ----- rtl/dbd_checker.sv -----
// dbd_checker: port-level assertions for detector_box_decode, and the bind
// that attaches them. Uses dbd_pkg for field widths.
module dbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [dbd_pkg::CLASS_W-1:0]    o_class_id,
    input logic [dbd_pkg::VALUE_W-1:0]    o_confidence,
    input logic [11:0]                    o_box_left,
    input logic [11:0]                    o_box_top,
    input logic [12:0]                    o_box_width,
    input logic [12:0]                    o_box_height
);
    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_class_id) && $stable(o_confidence)
            && $stable(o_box_left) && $stable(o_box_top)
            && $stable(o_box_width) && $stable(o_box_height)))
        else $error("result changed while waiting");

    // reset leaves both queues empty
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // after reset, no result reaches the output before the pipeline can refill
    a_reset_lat: assert property (@(posedge i_clk) !i_rst_n |=> ##3 empty)
        else $error("result appeared too soon after reset");

    // an empty box is reported as all zeros, never half zero
    a_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (((o_box_width == 13'd0) == (o_box_height == 13'd0))
            && (o_box_width != 13'd0 || (o_box_left == 12'd0 && o_box_top == 12'd0))))
        else $error("inconsistent empty box");
endmodule

bind detector_box_decode dbd_checker u_dbd_checker (.*);

// ----- tb/sv/tb_detector_box_decode.sv -----
`timescale 1ns / 1ps
// tb_detector_box_decode: self-checking bench for the detector box decoder.
// Needs dbd_pkg and detector_box_decode from the rtl folder.
module tb_detector_box_decode;

    localparam int VALUE_W         = dbd_pkg::VALUE_W;
    localparam int CLASS_W         = dbd_pkg::CLASS_W;
    localparam int INV_W           = dbd_pkg::INV_W;
    localparam int PAD_W           = dbd_pkg::PAD_W;
    localparam int IMG_W           = dbd_pkg::IMG_W;
    localparam int THR_W           = dbd_pkg::THR_W;
    localparam int NCLS_W          = dbd_pkg::NCLS_W;
    localparam int CFG_IDX_W       = dbd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = dbd_pkg::CFG_DATA_W;
    localparam int MAX_CLASSES_DEF = dbd_pkg::MAX_CLASSES_DEF;
    localparam int MAX_IMAGE_DEF   = dbd_pkg::MAX_IMAGE_DEF;
    localparam int FRAC_BITS_DEF   = dbd_pkg::FRAC_BITS_DEF;
    localparam int INV_FRAC        = dbd_pkg::INV_FRAC;

    typedef dbd_pkg::t_cfg     t_cfg;
    typedef dbd_pkg::t_result  t_result;
    typedef dbd_pkg::t_reg_idx t_reg_idx;

    localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest legal run
    localparam int SETTLE_CYCLES = 12;      // covers the back stages and both queues, with margin
    localparam int RANDOM_ITEMS  = 780;     // directed tests add about 280 more
    localparam int SCALE_SH      = FRAC_BITS_DEF + INV_FRAC;  // product fraction bits

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic [VALUE_W-1:0]    i_value     = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [CLASS_W-1:0]    o_class_id;
    logic [VALUE_W-1:0]    o_confidence;
    logic [11:0]           o_box_left;
    logic [11:0]           o_box_top;
    logic [12:0]           o_box_width;
    logic [12:0]           o_box_height;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    detector_box_decode dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_value      (i_value),
        .empty        (empty),
        .pop          (pop),
        .o_class_id   (o_class_id),
        .o_confidence (o_confidence),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: register shadow, row progress, expected boxes
    // ------------------------------------------------------------------
    t_cfg               cfg_shadow;
    int unsigned        row_pos;
    logic [VALUE_W-1:0] row_coord [4];     // cx, cy, w, h of the open row
    logic [VALUE_W-1:0] lead_score;
    int unsigned        lead_class;
    t_result            box_queue [$];     // boxes predicted, not yet popped

    int unsigned items_sent    = 0;
    int unsigned mismatches    = 0;
    int          push_idle_pct = 18;
    int          pop_idle_pct  = 18;       // read by the checker, change with <=

    // Clamped class count, as the block applies it.
    function automatic int unsigned class_count();
        int unsigned n;
        n = cfg_shadow.class_cnt;
        if (n == 0) n = 1;
        if (n > MAX_CLASSES_DEF) n = MAX_CLASSES_DEF;
        return n;
    endfunction

    // One axis: rounded, zero-clamped start edge and rounded extent in
    // source pixels. Products keep FRAC_BITS+16 fraction bits, exactly.
    function automatic void scale_axis(input logic [VALUE_W-1:0] ctr, ext_in,
                                       input logic [PAD_W-1:0] pad,
                                       input logic [INV_W-1:0] inv,
                                       output longint edge_lo, output longint extent);
        longint centre, pos, ext, num;
        centre  = longint'(ctr) - (longint'(pad) << FRAC_BITS_DEF);
        pos     = centre * longint'(inv);
        ext     = longint'(ext_in) * longint'(inv);
        // 2X - W + half, so left = round-half-up(X - W/2)
        num     = 2 * pos - ext + (longint'(1) << SCALE_SH);
        edge_lo = (num < 0) ? 0 : (num >>> (SCALE_SH + 1));
        extent  = (ext + (longint'(1) << (SCALE_SH - 1))) >>> SCALE_SH;
    endfunction

    // Advance the row by one accepted value; queue a box when the row
    // closes with a best score at or above the threshold.
    function automatic void predict_value(input logic [VALUE_W-1:0] v);
        int unsigned idx;
        longint      lft, top, wid, hgt, rgt, bot, iw, ih;
        t_result     box;
        if (row_pos < 4) begin
            row_coord[row_pos] = v;
            row_pos++;
            return;
        end
        idx = row_pos - 4;
        // strict compare: the earlier class keeps a tie
        if (idx == 0 || v > lead_score) begin
            lead_score = v;
            lead_class = idx;
        end
        // a lowered class count closes the row at the first score past its end
        if (idx + 1 < class_count()) begin
            row_pos++;
            return;
        end
        row_pos = 0;
        if (lead_score < cfg_shadow.score_threshold) return;

        scale_axis(row_coord[0], row_coord[2], cfg_shadow.pad_left,
                   cfg_shadow.inv_ratio_x, lft, wid);
        scale_axis(row_coord[1], row_coord[3], cfg_shadow.pad_top,
                   cfg_shadow.inv_ratio_y, top, hgt);
        iw  = (cfg_shadow.image_width > MAX_IMAGE_DEF) ? MAX_IMAGE_DEF
                                                       : cfg_shadow.image_width;
        ih  = (cfg_shadow.image_height > MAX_IMAGE_DEF) ? MAX_IMAGE_DEF
                                                        : cfg_shadow.image_height;
        rgt = (lft + wid > iw) ? iw : lft + wid;
        bot = (top + hgt > ih) ? ih : top + hgt;

        box.class_id   = CLASS_W'(lead_class);
        box.confidence = lead_score;
        if (rgt <= lft || bot <= top) begin
            // box falls outside the image: geometry reported as all zero
            box.box_left   = '0;
            box.box_top    = '0;
            box.box_width  = '0;
            box.box_height = '0;
        end else begin
            box.box_left   = 12'(lft);
            box.box_top    = 12'(top);
            box.box_width  = 13'(rgt - lft);
            box.box_height = 13'(bot - top);
        end
        box_queue.insert(box_queue.size(), box);
    endfunction

    // ------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------
    // One value request. push stays high afterward so back-to-back requests
    // never lower and raise it in the same step; idle gaps lower it first.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (full !== 1'b0);
        predict_value(v);
        items_sent++;
    endtask

    // Write enable is left high; apply_config drops it after the last write.
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(dbd_pkg::REG_SCORE_THRESHOLD, CFG_DATA_W'(c.score_threshold));
        write_reg(dbd_pkg::REG_INV_RATIO_X,     CFG_DATA_W'(c.inv_ratio_x));
        write_reg(dbd_pkg::REG_INV_RATIO_Y,     CFG_DATA_W'(c.inv_ratio_y));
        write_reg(dbd_pkg::REG_PAD_LEFT,        CFG_DATA_W'(c.pad_left));
        write_reg(dbd_pkg::REG_PAD_TOP,         CFG_DATA_W'(c.pad_top));
        write_reg(dbd_pkg::REG_IMAGE_WIDTH,     CFG_DATA_W'(c.image_width));
        write_reg(dbd_pkg::REG_IMAGE_HEIGHT,    CFG_DATA_W'(c.image_height));
        write_reg(dbd_pkg::REG_CLASS_CNT,       CFG_DATA_W'(c.class_cnt));
        i_cfg_we   <= 1'b0;
        cfg_shadow  = c;
    endtask

    // Block is idle once every predicted box is out and the pipeline has
    // had time to drop rows that produce nothing.
    task automatic wait_results_done();
        push <= 1'b0;
        while (box_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Four coordinates then n_scores scores. Centers mostly land inside the
    // padded area so boxes are meaningful; a quarter are raw 24-bit noise.
    task automatic send_row(input int unsigned n_scores);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] prev;
        int                 s;
        int unsigned        pad;
        prev = '0;
        for (int j = 0; j < 4; j++) begin
            pad = (j == 0) ? cfg_shadow.pad_left : (j == 1) ? cfg_shadow.pad_top : 0;
            if ($urandom_range(0, 3) == 0)
                v = VALUE_W'($urandom);
            else if (j < 2)
                v = {10'(pad + $urandom_range(0, 1023 - pad)), 14'($urandom)};
            else
                v = {10'($urandom_range(0, 700)), 14'($urandom)};
            send_value(v);
        end
        for (int k = 0; k < n_scores; k++) begin
            case ($urandom_range(0, 4))
                0: v = VALUE_W'($urandom);
                1: begin  // hug the threshold
                    s = int'(cfg_shadow.score_threshold) + int'($urandom_range(0, 4)) - 2;
                    v = (s < 0) ? '0 : VALUE_W'(s);
                end
                2: v = VALUE_W'($urandom_range(0, 32767));
                3: v = prev;  // tie with the previous class
                default: v = VALUE_W'($urandom_range(0, 255));
            endcase
            prev = v;
            send_value(v);
        end
    endtask

    function automatic logic [INV_W-1:0] pick_ratio();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return INV_W'($urandom);
            default: return INV_W'($urandom_range(16384, 262144));  // 0.25 .. 4.0
        endcase
    endfunction

    function automatic logic [PAD_W-1:0] pick_pad();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            default: return PAD_W'($urandom_range(0, 200));
        endcase
    endfunction

    function automatic logic [IMG_W-1:0] pick_image();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return IMG_W'(MAX_IMAGE_DEF);
            2: return IMG_W'($urandom);  // may exceed the clip limit
            3: return IMG_W'(1);
            default: return IMG_W'($urandom_range(64, 2000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Rows under the reset values of all registers (80 classes).
    task automatic test_reset_values();
        repeat (3) send_row(class_count());
        wait_results_done();
    endtask

    // All-zero and all-one values, zero threshold with a zero score,
    // class count 0 taken as 1, widest ratio and padding.
    task automatic test_extreme_fields();
        t_cfg c;
        c = '{score_threshold: '0, inv_ratio_x: '1, inv_ratio_y: INV_W'(65536),
              pad_left: '0, pad_top: '1, image_width: IMG_W'(MAX_IMAGE_DEF),
              image_height: IMG_W'(MAX_IMAGE_DEF), class_cnt: '0};
        apply_config(c);
        send_value('0);
        send_value('1);
        send_value('1);
        send_value('1);
        send_value('0);
        wait_results_done();
    endtask

    // Equal best scores keep the first class; a score equal to the
    // threshold passes; image width above the clip limit, height of one.
    task automatic test_tie_at_threshold();
        t_cfg c;
        c = '{score_threshold: THR_W'(16384), inv_ratio_x: INV_W'(65536),
              inv_ratio_y: INV_W'(65536), pad_left: '0, pad_top: '0,
              image_width: '1, image_height: IMG_W'(1), class_cnt: NCLS_W'(3)};
        apply_config(c);
        send_value({10'd320, 14'd0});
        send_value({10'd0, 14'h2000});
        send_value({10'd100, 14'd0});
        send_value({10'd2, 14'd0});
        send_value(VALUE_W'(16384));
        send_value(VALUE_W'(16384));
        send_value(VALUE_W'(7));
        wait_results_done();
    endtask

    // Zero ratio and zero image width: nothing left after clipping.
    task automatic test_empty_box();
        t_cfg c;
        c = '{score_threshold: '0, inv_ratio_x: '0, inv_ratio_y: INV_W'(65536),
              pad_left: '0, pad_top: '0, image_width: '0,
              image_height: IMG_W'(640), class_cnt: NCLS_W'(1)};
        apply_config(c);
        send_value({10'd100, 14'd0});
        send_value({10'd100, 14'd0});
        send_value({10'd50, 14'd0});
        send_value({10'd50, 14'd0});
        send_value('1);
        wait_results_done();
    endtask

    // Class count dropped while a row is open: the next score closes it.
    task automatic test_class_count_lowered();
        t_cfg c;
        c = '{score_threshold: '0, inv_ratio_x: INV_W'(65536),
              inv_ratio_y: INV_W'(65536), pad_left: '0, pad_top: '0,
              image_width: IMG_W'(640), image_height: IMG_W'(640),
              class_cnt: NCLS_W'(4)};
        apply_config(c);
        send_value({10'd200, 14'd0});
        send_value({10'd150, 14'd0});
        send_value({10'd40, 14'd0});
        send_value({10'd30, 14'd0});
        send_value(VALUE_W'(500));
        wait_results_done();
        c.class_cnt = NCLS_W'(1);
        apply_config(c);
        send_value(VALUE_W'(900));
        wait_results_done();
    endtask

    // One random register setting, then whole rows with random content.
    task automatic run_random_phase(input int phase_no);
        t_cfg        c;
        int unsigned rows;
        case ($urandom_range(0, 9))
            0: c.score_threshold = '0;
            1: c.score_threshold = THR_W'(16384);
            2: c.score_threshold = THR_W'($urandom);
            default: c.score_threshold = THR_W'($urandom_range(0, 16384));
        endcase
        c.inv_ratio_x  = pick_ratio();
        c.inv_ratio_y  = pick_ratio();
        c.pad_left     = pick_pad();
        c.pad_top      = pick_pad();
        c.image_width  = pick_image();
        c.image_height = pick_image();
        case ($urandom_range(0, 19))
            0: c.class_cnt = '0;
            1: c.class_cnt = NCLS_W'($urandom_range(129, 255));
            2, 3: c.class_cnt = NCLS_W'($urandom_range(9, 128));
            default: c.class_cnt = NCLS_W'($urandom_range(1, 8));
        endcase
        if (phase_no == 0) c.class_cnt = '1;  // above the class limit, once for sure
        apply_config(c);

        // finish any row left open by the previous phase under the new count
        while (row_pos != 0) send_value(VALUE_W'($urandom));

        rows = (class_count() > 16) ? $urandom_range(1, 2) : $urandom_range(4, 14);
        repeat (rows) send_row(class_count());
        // now and then leave a row cut short
        if ($urandom_range(0, 4) == 0) send_row($urandom_range(0, class_count() - 1));
        wait_results_done();
    endtask

    task automatic test_random_rows();
        int unsigned first_item;
        int          phase_no;
        first_item = items_sent;
        phase_no   = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            // phase 2 runs with both sides streaming flat out
            if (phase_no == 2) begin
                push_idle_pct = 0;
                pop_idle_pct <= 0;
            end
            run_random_phase(phase_no);
            if (phase_no == 2) begin
                push_idle_pct = 18;
                pop_idle_pct <= 18;
            end
            phase_no++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random pop, compare each popped box with the oldest
    // prediction. Values read here are the ones held at the clock edge.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want_v, got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : box_checker
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (box_queue.size() == 0) begin
                $display("%0t: box popped with no request pending, class %0d conf %0d",
                         $time, o_class_id, o_confidence);
                mismatches++;
            end else begin
                want = box_queue.pop_front();
                check_field("class_id",   want.class_id,   o_class_id);
                check_field("confidence", want.confidence, o_confidence);
                check_field("box_left",   want.box_left,   o_box_left);
                check_field("box_top",    want.box_top,    o_box_top);
                check_field("box_width",  want.box_width,  o_box_width);
                check_field("box_height", want.box_height, o_box_height);
            end
        end
        pop <= i_rst_n && ($urandom_range(0, 99) >= pop_idle_pct);
    end

    // Hard stop if the run hangs.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_shadow = '{score_threshold: THR_W'(4096), inv_ratio_x: INV_W'(65536),
                       inv_ratio_y: INV_W'(65536), pad_left: '0, pad_top: '0,
                       image_width: IMG_W'(640), image_height: IMG_W'(640),
                       class_cnt: NCLS_W'(80)};
        row_pos    = 0;
        lead_score = '0;
        lead_class = 0;
        foreach (row_coord[i]) row_coord[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_extreme_fields();
        test_tie_at_threshold();
        test_empty_box();
        test_class_count_lowered();
        test_random_rows();

        wait_results_done();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dbd_pkg.sv
rtl/dbd_fifo.sv
rtl/dbd_front.sv
rtl/dbd_back.sv
rtl/detector_box_decode.sv
rtl/dbd_checker.sv
tb/sv/tb_detector_box_decode.sv
